// ===== rtl/bdpq_pkg.sv =====
package bdpq_pkg;

   // Number of cells in the chain, one entry per cell.
   localparam int CAPACITY = 64;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int CSR_W    = 7;
   localparam int CMP_W    = (COUNT_W > CSR_W) ? COUNT_W : CSR_W;
   localparam int RISK_W   = 16;
   localparam int ID_W     = 16;

   // Request operation codes.
   localparam logic [1:0] OP_INSERT     = 2'd0;
   localparam logic [1:0] OP_DELETE_MIN = 2'd1;
   localparam logic [1:0] OP_DELETE_MAX = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_EVICTED = 2'd1;
   localparam logic [1:0] STATUS_EMPTY   = 2'd2;

   // One stored entry as seen by a neighboring cell.
   typedef struct packed {
      logic              valid;
      logic [RISK_W-1:0] risk;
      logic [ID_W-1:0]   entry_id;
   } entry_type;

   // Command broadcast to every cell of the chain.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE_MIN,
      CELL_REMOVE_MAX
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type      cmd;
      logic [RISK_W-1:0] risk;
      logic [ID_W-1:0]   entry_id;
      logic [RISK_W-1:0] top_risk;
   } cell_ctrl_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVICT,
      ST_INSERT,
      ST_REMOVE,
      ST_TOP,
      ST_SHOW
   } state_type;

endpackage

// ===== rtl/bdpq_cell.sv =====
// One cell of the sorted chain. The chain is kept in ascending risk order;
// among equal risks the newest entry stands first. Empty cells sit at the end.
module bdpq_cell
   import bdpq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  entry_type     left_entry,
   input  logic          left_ge,
   input  entry_type     right_entry,
   output entry_type     entry,
   output logic          ge,
   output logic          is_head
);

   logic              valid_ff;
   logic              valid_in;
   logic [RISK_W-1:0] risk_ff;
   logic [RISK_W-1:0] risk_in;
   logic [ID_W-1:0]   id_ff;
   logic [ID_W-1:0]   id_in;
   logic              at_top;

   assign entry = '{valid: valid_ff, risk: risk_ff, entry_id: id_ff};

   // This cell lies at or after the insert position.
   assign ge = !valid_ff || (risk_ff >= ctrl.risk);

   // First (newest) cell of the group holding the largest risk.
   assign at_top  = valid_ff && (risk_ff == ctrl.top_risk);
   assign is_head = at_top && !(left_entry.valid && (left_entry.risk == risk_ff));

   // Next contents: hold, shift right for an insert, or shift left for a removal.
   always_comb begin
      valid_in = valid_ff;
      risk_in  = risk_ff;
      id_in    = id_ff;
      case (ctrl.cmd)
         CELL_INSERT: begin
            if (ge) begin
               if (left_ge) begin
                  valid_in = left_entry.valid;
                  risk_in  = left_entry.risk;
                  id_in    = left_entry.entry_id;
               end else begin
                  valid_in = 1'b1;
                  risk_in  = ctrl.risk;
                  id_in    = ctrl.entry_id;
               end
            end
         end
         CELL_REMOVE_MIN: begin
            valid_in = right_entry.valid;
            risk_in  = right_entry.risk;
            id_in    = right_entry.entry_id;
         end
         CELL_REMOVE_MAX: begin
            if (!valid_ff || at_top) begin
               valid_in = right_entry.valid;
               risk_in  = right_entry.risk;
               id_in    = right_entry.entry_id;
            end
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   // The valid bit is cleared at reset; payload needs none.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      risk_ff <= risk_in;
      id_ff   <= id_in;
   end

endmodule

// ===== rtl/bounded_double_ended_priority_queue.sv =====
// Channel    Handshake               Payload
// request    start / busy            req_op, req_risk, req_entry_id
// result     rsp_valid (one cycle)   rsp_status, rsp_empty_res, rsp_count,
//                                    rsp_min_risk, rsp_min_id, rsp_max_risk, rsp_max_id
// config     csr_write_enable        csr_write_data (capacity)
//
// An insert or a delete on a nonempty queue shifts the chain once; an evicting insert first
// shifts it left to drop the minimum; a delete on an empty queue or an unknown op does not
// shift it. Then the largest risk is located and the newest entry of that risk is selected;
// the result shows in the cycle busy falls.
// Reset clears all cell valid bits, the count and the capacity to its full value.
// The receiver cannot stall: each result stands for exactly one cycle.
module bounded_double_ended_priority_queue
   import bdpq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_op,
   input  logic [RISK_W-1:0]   req_risk,
   input  logic [ID_W-1:0]     req_entry_id,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic                rsp_empty_res,
   output logic [CSR_W-1:0]    rsp_count,
   output logic [RISK_W-1:0]   rsp_min_risk,
   output logic [ID_W-1:0]     rsp_min_id,
   output logic [RISK_W-1:0]   rsp_max_risk,
   output logic [ID_W-1:0]     rsp_max_id,
   input  logic                csr_write_enable,
   input  logic [CSR_W-1:0]    csr_write_data
);

   state_type         state_ff;
   state_type         state_in;
   logic [CSR_W-1:0]  capacity_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [1:0]        op_ff;
   logic [RISK_W-1:0] risk_ff;
   logic [ID_W-1:0]   id_ff;
   logic [1:0]        status_ff;
   logic [1:0]        status_in;
   logic [RISK_W-1:0] top_risk_ff;
   logic [RISK_W-1:0] top_risk_in;

   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic              rsp_empty_ff;
   logic [CSR_W-1:0]  rsp_count_ff;
   logic [RISK_W-1:0] rsp_min_risk_ff;
   logic [RISK_W-1:0] rsp_min_risk_in;
   logic [ID_W-1:0]   rsp_min_id_ff;
   logic [ID_W-1:0]   rsp_min_id_in;
   logic [RISK_W-1:0] rsp_max_risk_ff;
   logic [RISK_W-1:0] rsp_max_risk_in;
   logic [ID_W-1:0]   rsp_max_id_ff;
   logic [ID_W-1:0]   rsp_max_id_in;

   logic              accept;
   logic              full;
   logic [CMP_W-1:0]  eff_cap;
   logic [CMP_W-1:0]  cap_ext;
   cell_ctrl_type     ctrl;
   cell_cmd_type      cmd;

   entry_type         entry_vec [CAPACITY];
   logic              ge_vec    [CAPACITY];
   logic              head_vec  [CAPACITY];
   logic [CAPACITY-1:0] head_bits;

   assign accept = start && !busy;

   // Effective capacity: zero counts as one, large values saturate.
   assign cap_ext = CMP_W'(capacity_ff);
   always_comb begin
      if (capacity_ff == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(CAPACITY)) begin
         eff_cap = CMP_W'(CAPACITY);
      end else begin
         eff_cap = cap_ext;
      end
   end
   assign full = CMP_W'(count_ff) >= eff_cap;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_INSERT) begin
                  state_in = full ? ST_EVICT : ST_INSERT;
               end else if ((req_op == OP_DELETE_MIN || req_op == OP_DELETE_MAX) &&
                            (count_ff != '0)) begin
                  state_in = ST_REMOVE;
               end else begin
                  state_in = ST_TOP;
               end
            end
         end
         ST_EVICT:  state_in = ST_INSERT;
         ST_INSERT: state_in = ST_TOP;
         ST_REMOVE: state_in = ST_TOP;
         ST_TOP:    state_in = ST_SHOW;
         ST_SHOW:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: chain command and busy.
   always_comb begin
      cmd  = CELL_HOLD;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE:   busy = 1'b0;
         ST_EVICT:  cmd = CELL_REMOVE_MIN;
         ST_INSERT: cmd = CELL_INSERT;
         ST_REMOVE: cmd = (op_ff == OP_DELETE_MAX) ? CELL_REMOVE_MAX : CELL_REMOVE_MIN;
         default:   cmd = CELL_HOLD;
      endcase
   end

   assign ctrl = '{cmd: cmd, risk: risk_ff, entry_id: id_ff, top_risk: top_risk_ff};

   // The chain of cells; the ends see an empty neighbor.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type left_e;
      entry_type right_e;
      logic      left_g;
      if (i == 0) begin : g_first
         assign left_e = '0;
         assign left_g = 1'b0;
      end else begin : g_inner_left
         assign left_e = entry_vec[i-1];
         assign left_g = ge_vec[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_e = '0;
      end else begin : g_inner_right
         assign right_e = entry_vec[i+1];
      end
      bdpq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_entry  (left_e),
         .left_ge     (left_g),
         .right_entry (right_e),
         .entry       (entry_vec[i]),
         .ge          (ge_vec[i]),
         .is_head     (head_vec[i])
      );
      assign head_bits[i] = head_vec[i];
   end

   // Largest risk: the last occupied cell, picked by a one-hot select.
   always_comb begin
      top_risk_in = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (entry_vec[i].valid &&
             ((i == CAPACITY - 1) || !entry_vec[(i + 1) % CAPACITY].valid)) begin
            top_risk_in = top_risk_in | entry_vec[i].risk;
         end
      end
   end

   // Result view: minimum from the first cell, maximum from the head of the top group.
   always_comb begin
      rsp_min_risk_in = entry_vec[0].valid ? entry_vec[0].risk : '0;
      rsp_min_id_in   = entry_vec[0].valid ? entry_vec[0].entry_id : '0;
      rsp_max_risk_in = '0;
      rsp_max_id_in   = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (head_vec[i]) begin
            rsp_max_risk_in = rsp_max_risk_in | entry_vec[i].risk;
            rsp_max_id_in   = rsp_max_id_in | entry_vec[i].entry_id;
         end
      end
   end

   // Count and status bookkeeping.
   always_comb begin
      count_in  = count_ff;
      status_in = status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               status_in = STATUS_DONE;
               if (req_op == OP_INSERT && full) begin
                  status_in = STATUS_EVICTED;
               end else if ((req_op == OP_DELETE_MIN || req_op == OP_DELETE_MAX) &&
                            (count_ff == '0)) begin
                  status_in = STATUS_EMPTY;
               end
            end
         end
         ST_EVICT:  count_in = count_ff - COUNT_W'(1);
         ST_INSERT: count_in = count_ff + COUNT_W'(1);
         ST_REMOVE: count_in = count_ff - COUNT_W'(1);
         default:   count_in = count_ff;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         capacity_ff  <= CSR_W'(CAPACITY);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= (state_ff == ST_SHOW);
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
      end
   end

   // Request capture and result registers.
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      if (accept) begin
         op_ff   <= req_op;
         risk_ff <= req_risk;
         id_ff   <= req_entry_id;
      end
      if (state_ff == ST_TOP) begin
         top_risk_ff <= top_risk_in;
      end
      if (state_ff == ST_SHOW) begin
         rsp_status_ff   <= status_ff;
         rsp_empty_ff    <= (count_ff == '0);
         rsp_count_ff    <= CSR_W'(count_ff);
         rsp_min_risk_ff <= rsp_min_risk_in;
         rsp_min_id_ff   <= rsp_min_id_in;
         rsp_max_risk_ff <= rsp_max_risk_in;
         rsp_max_id_ff   <= rsp_max_id_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_empty_res = rsp_empty_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_min_risk  = rsp_min_risk_ff;
   assign rsp_min_id    = rsp_min_id_ff;
   assign rsp_max_risk  = rsp_max_risk_ff;
   assign rsp_max_id    = rsp_max_id_ff;

`ifndef SYNTHESIS
   // A result appears only after the view was taken.
   a_rsp_after_show: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_SHOW))
      else $error("result strobe without a view cycle");

   // The count never exceeds the chain length.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      COUNT_W'(CAPACITY) >= count_ff)
      else $error("count beyond the number of cells");

   // While idle, the first cell is occupied exactly when the count is nonzero.
   a_count_matches_chain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ((count_ff == '0) == !entry_vec[0].valid))
      else $error("count disagrees with the chain");

   // At most one cell heads the group of the largest risk.
   a_single_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHOW) |-> $onehot0(head_bits))
      else $error("more than one maximum head");

   // A nonempty queue always yields a maximum head when the view is taken.
   a_head_present: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SHOW) && (count_ff != '0)) |-> (head_bits != '0))
      else $error("no maximum head in a nonempty queue");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import bdpq_pkg::*;

   // The package names only the three real operations; code 3 must be ignored.
   localparam logic [1:0] OP_UNKNOWN = 2'd3;
   localparam int SETTLE_CYCLES      = 8;
   localparam int MAX_PRINTED        = 50;

   // Everything a result reports about the queue after one request.
   typedef struct packed {
      logic [1:0]        status;
      logic              empty_res;
      logic [CSR_W-1:0]  count;
      logic [RISK_W-1:0] min_risk;
      logic [ID_W-1:0]   min_id;
      logic [RISK_W-1:0] max_risk;
      logic [ID_W-1:0]   max_id;
   } queue_view_type;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              start            = 1'b0;
   logic              busy;
   logic [1:0]        req_op           = OP_INSERT;
   logic [RISK_W-1:0] req_risk         = '0;
   logic [ID_W-1:0]   req_entry_id     = '0;
   logic              rsp_valid;
   logic [1:0]        rsp_status;
   logic              rsp_empty_res;
   logic [CSR_W-1:0]  rsp_count;
   logic [RISK_W-1:0] rsp_min_risk;
   logic [ID_W-1:0]   rsp_min_id;
   logic [RISK_W-1:0] rsp_max_risk;
   logic [ID_W-1:0]   rsp_max_id;
   logic              csr_write_enable = 1'b0;
   logic [CSR_W-1:0]  csr_write_data   = '0;

   // Shadow copy of the queue contents, one entry per slot.
   bit                cell_used  [CAPACITY];
   logic [RISK_W-1:0] cell_risk  [CAPACITY];
   logic [ID_W-1:0]   cell_id    [CAPACITY];
   logic [31:0]       cell_stamp [CAPACITY];
   logic [31:0]       insert_serial;
   int                held;
   logic [CSR_W-1:0]  capacity_setting;

   queue_view_type expected_views[$];
   int             error_count = 0;

   bounded_double_ended_priority_queue uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_risk         (req_risk),
      .req_entry_id     (req_entry_id),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_empty_res    (rsp_empty_res),
      .rsp_count        (rsp_count),
      .rsp_min_risk     (rsp_min_risk),
      .rsp_min_id       (rsp_min_id),
      .rsp_max_risk     (rsp_max_risk),
      .rsp_max_id       (rsp_max_id),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #10 clock = ~clock;

   // Queue shadow: reset, search and update.

   function automatic void clear_queue_shadow();
      for (int s = 0; s < CAPACITY; s++) begin
         cell_used[s]  = 1'b0;
         cell_risk[s]  = '0;
         cell_id[s]    = '0;
         cell_stamp[s] = '0;
      end
      insert_serial    = '0;
      held             = 0;
      capacity_setting = CSR_W'(CAPACITY);
   endfunction

   // Slot of the newest entry with the smallest or largest risk, -1 when empty.
   // Recency is the wrapped distance from the insert serial number.
   function automatic int find_extreme(input bit want_max);
      int          best;
      logic [31:0] age_s;
      logic [31:0] age_best;
      best = -1;
      for (int s = 0; s < CAPACITY; s++) begin
         if (cell_used[s]) begin
            if (best < 0) begin
               best = s;
            end else if (cell_risk[s] == cell_risk[best]) begin
               age_s    = insert_serial - cell_stamp[s];
               age_best = insert_serial - cell_stamp[best];
               if (age_s < age_best) best = s;
            end else if (want_max ? (cell_risk[s] > cell_risk[best])
                                  : (cell_risk[s] < cell_risk[best])) begin
               best = s;
            end
         end
      end
      return best;
   endfunction

   function automatic void drop_cell(input int s);
      if (s >= 0 && cell_used[s]) begin
         cell_used[s] = 1'b0;
         if (held > 0) held--;
      end
   endfunction

   // Applies one request to the shadow and returns the view it should report.
   function automatic queue_view_type apply_request(input logic [1:0] op,
                                                    input logic [RISK_W-1:0] risk,
                                                    input logic [ID_W-1:0] id);
      queue_view_type view;
      int             limit;
      int             lo;
      int             hi;
      bit             placed;
      view        = '0;
      view.status = STATUS_DONE;
      // A capacity of zero acts as one, anything above the slot count saturates.
      if (capacity_setting == 0) limit = 1;
      else if (capacity_setting > CAPACITY) limit = CAPACITY;
      else limit = int'(capacity_setting);

      if (op == OP_INSERT) begin
         // A full queue, or one over a lowered capacity, loses its minimum first.
         if (held >= limit) begin
            drop_cell(find_extreme(1'b0));
            view.status = STATUS_EVICTED;
         end
         placed = 1'b0;
         for (int s = 0; s < CAPACITY; s++) begin
            if (!placed && !cell_used[s]) begin
               cell_used[s]  = 1'b1;
               cell_risk[s]  = risk;
               cell_id[s]    = id;
               cell_stamp[s] = insert_serial;
               insert_serial = insert_serial + 32'd1;
               held++;
               placed = 1'b1;
            end
         end
      end else if (op == OP_DELETE_MIN || op == OP_DELETE_MAX) begin
         if (held == 0) view.status = STATUS_EMPTY;
         else drop_cell(find_extreme(op == OP_DELETE_MAX));
      end

      lo             = find_extreme(1'b0);
      hi             = find_extreme(1'b1);
      view.empty_res = (held == 0);
      view.count     = held[CSR_W-1:0];
      if (lo >= 0) begin
         view.min_risk = cell_risk[lo];
         view.min_id   = cell_id[lo];
      end
      if (hi >= 0) begin
         view.max_risk = cell_risk[hi];
         view.max_id   = cell_id[hi];
      end
      return view;
   endfunction

   // Mismatch reporting; printing stops after a while but counting does not.

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTED) $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Every result is compared with the oldest outstanding prediction.
   always @(posedge clock) begin
      queue_view_type want;
      if (!reset && rsp_valid) begin
         if (expected_views.size() == 0) begin
            report_mismatch("result with no request outstanding");
         end else begin
            want = expected_views.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
            if (rsp_empty_res !== want.empty_res)
               report_mismatch($sformatf("empty %0d, expected %0d",
                                         rsp_empty_res, want.empty_res));
            if (rsp_count !== want.count)
               report_mismatch($sformatf("count %0d, expected %0d", rsp_count, want.count));
            if (rsp_min_risk !== want.min_risk)
               report_mismatch($sformatf("min risk %0h, expected %0h",
                                         rsp_min_risk, want.min_risk));
            if (rsp_min_id !== want.min_id)
               report_mismatch($sformatf("min id %0h, expected %0h", rsp_min_id, want.min_id));
            if (rsp_max_risk !== want.max_risk)
               report_mismatch($sformatf("max risk %0h, expected %0h",
                                         rsp_max_risk, want.max_risk));
            if (rsp_max_id !== want.max_id)
               report_mismatch($sformatf("max id %0h, expected %0h", rsp_max_id, want.max_id));
         end
      end
   end

   // Request side helpers.

   // Holds a request until the block takes it, then records its prediction.
   // The start line is left high so a following request goes out back to back.
   task automatic send_request(input logic [1:0] op, input logic [RISK_W-1:0] risk,
                               input logic [ID_W-1:0] id);
      req_op       <= op;
      req_risk     <= risk;
      req_entry_id <= id;
      start        <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_views.push_back(apply_request(op, risk, id));
   endtask

   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stops sending until every outstanding result is back and the block is quiet.
   task automatic drain_results();
      start <= 1'b0;
      while (expected_views.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CSR_W-1:0] value);
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      capacity_setting = value;
      csr_write_enable <= 1'b0;
   endtask

   // Tests.

   // Deletes and an unknown operation on a queue that holds nothing.
   task automatic test_empty_queue();
      send_request(OP_DELETE_MIN, 16'h1234, 16'h5678);
      send_request(OP_DELETE_MAX, 16'hffff, 16'hffff);
      send_request(OP_UNKNOWN, 16'h0000, 16'h0000);
   endtask

   // Extreme keys and ids, and ties on both ends where the newest entry wins.
   task automatic test_field_extremes();
      send_request(OP_INSERT, 16'h0000, 16'h0000);
      send_request(OP_INSERT, 16'hffff, 16'hffff);
      send_request(OP_INSERT, 16'h0000, 16'h1234);
      send_request(OP_INSERT, 16'hffff, 16'h5a5a);
      send_request(OP_UNKNOWN, 16'hffff, 16'hffff);
      send_request(OP_DELETE_MAX, 16'h0000, 16'h0000);
      send_request(OP_DELETE_MIN, 16'h0000, 16'h0000);
      send_request(OP_DELETE_MAX, 16'h0000, 16'h0000);
      send_request(OP_DELETE_MIN, 16'h0000, 16'h0000);
   endtask

   // Small capacities, capacity zero, a capacity under the count and saturation.
   task automatic test_capacity_limits();
      drain_results();
      write_capacity(7'd2);
      send_request(OP_INSERT, 16'h0300, 16'h0001);
      send_request(OP_INSERT, 16'h0100, 16'h0002);
      send_request(OP_INSERT, 16'h0200, 16'h0003);
      // Two entries held against an effective capacity of one.
      drain_results();
      write_capacity(7'd0);
      send_request(OP_INSERT, 16'h0050, 16'h0004);
      send_request(OP_DELETE_MIN, 16'h0000, 16'h0000);
      send_request(OP_DELETE_MIN, 16'h0000, 16'h0000);
      send_request(OP_INSERT, 16'h8000, 16'h0005);
      send_request(OP_INSERT, 16'h7fff, 16'h0006);
      drain_results();
      write_capacity(7'd127);
      send_request(OP_INSERT, 16'h4000, 16'h0007);
   endtask

   // One stretch of random requests under a given capacity, mix and idle rate.
   task automatic run_traffic_phase(input logic [CSR_W-1:0] cap, input int items,
                                    input int insert_pct, input int idle_pct);
      logic [1:0]        op;
      logic [RISK_W-1:0] risk;
      int                pick;
      drain_results();
      write_capacity(cap);
      for (int n = 0; n < items; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) op = OP_UNKNOWN;
         else if (pick < insert_pct) op = OP_INSERT;
         else if ($urandom_range(0, 1) == 1) op = OP_DELETE_MAX;
         else op = OP_DELETE_MIN;
         // A narrow key range makes ties common; full range covers every bit.
         case ($urandom_range(0, 3))
            0: risk = RISK_W'($urandom_range(0, 7));
            1: risk = ($urandom_range(0, 1) == 1) ? '1 : '0;
            default: risk = RISK_W'($urandom);
         endcase
         send_request(op, risk, ID_W'($urandom));
         if ($urandom_range(0, 99) < idle_pct) pause_sender(int'($urandom_range(1, 6)));
      end
   endtask

   task automatic test_random_traffic();
      run_traffic_phase(7'd64, 160, 50, 0);
      run_traffic_phase(7'd5, 160, 55, 50);
      // Insert heavy so the queue fills and evicts at full capacity.
      run_traffic_phase(7'd64, 170, 85, 0);
      // Capacity drops far below the count left by the phase before.
      run_traffic_phase(7'd1, 120, 50, 10);
      run_traffic_phase(7'd127, 170, 70, 50);
      run_traffic_phase(7'd0, 60, 50, 0);
      run_traffic_phase(7'd40, 110, 60, 10);
   endtask

   // Test sequence.
   initial begin
      clear_queue_shadow();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_empty_queue();
      test_field_extremes();
      test_capacity_limits();
      test_random_traffic();
      drain_results();
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/bdpq_pkg.sv
rtl/bdpq_cell.sv
rtl/bounded_double_ended_priority_queue.sv
tb/sv/tb.sv
